// ===== hdl/letg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table of the envelope tone generator.
// Used by every module of the block; depends on nothing else.
package letg_pkg;

	// Sine table depth, sample index width and the widths they imply.
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int INDEX_WIDTH      = 20;
	localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH + 1);

	// Fixed register and field widths.
	localparam int STEP_W      = 32;
	localparam int AMP_W       = 15;
	localparam int TONE_LEN_W  = 20;
	localparam int RAMP_LEN_W  = 17;
	localparam int RAMP_INV_W  = 24;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int SAMPLE_W    = 16;
	localparam int SINE_W      = 15;
	localparam int ENV_W       = 25;
	localparam int ENV_PROD_W  = RAMP_LEN_W + RAMP_INV_W;
	localparam int MAG_AMP_W   = SINE_W + AMP_W;
	localparam int PROD_W      = MAG_AMP_W + ENV_W;

	// Index compare width: wide enough for either operand plus one carry bit.
	localparam int CMP_W = ((INDEX_WIDTH > TONE_LEN_W) ? INDEX_WIDTH : TONE_LEN_W) + 1;

	// Envelope value of 1.0 in Q1.24.
	localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << 24;

	// Reset value of the amplitude register.
	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(6553);

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PHASE_STEP   = 3'd0,
		REG_AMPLITUDE    = 3'd1,
		REG_TONE_LENGTH  = 3'd2,
		REG_RAMP_LENGTH  = 3'd3,
		REG_RAMP_INVERSE = 3'd4
	} reg_index_t;

	// Current configuration, as held by the register file.
	typedef struct packed {
		logic [STEP_W-1:0]     phase_step;
		logic [AMP_W-1:0]      amplitude;
		logic [TONE_LEN_W-1:0] tone_length;
		logic [RAMP_LEN_W-1:0] ramp_length;
		logic [RAMP_INV_W-1:0] ramp_inverse;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic lookup;
		logic scale;
		logic mult;
		logic emit;
	} cmd_t;

	typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	// One table entry: round(32767*sin(x)) from a Q30 odd polynomial in Horner form.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		x  = (64'd1686629713 * 64'(k)) / SINE_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		t  = 64'd1 << 30;
		t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd156;
		t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
		t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
		t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
		t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
		t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		return e[SINE_W-1:0];
	endfunction

	// Whole quarter-wave table, built at elaboration.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			rom[k] = sine_entry(k);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== hdl/linear_envelope_tone_generator.sv =====
`timescale 1ns / 1ps
// Top level of the envelope tone generator: register file, controller and datapath.
// Depends on letg_pkg, letg_regs, letg_ctrl and letg_datapath.
//
// Usage: each item on the input channel (in_valid/in_ready, field restart) is one
// sample tick and yields exactly one result item on the output channel
// (out_valid/out_ready, fields sample_value, active, last). With restart high the
// phase and sample index go to zero before that sample is made.
// Each item passes through the four controller steps (table lookup, amplitude
// multiply, envelope multiply, rounding) and its result is loaded into the output
// register when that register is free. No new item is taken while one is in work
// but in the same cycle the previous result enters the output register.
// A stalled receiver holds the result in the output register; one more item is
// taken and carried to its last step, then input waits until the output frees.
// Configuration: cfg_write_en with cfg_index and cfg_data writes a register at once;
// indexes beyond the register list are ignored. Write only while no item is in work.
// Reset (arst_n low) clears the phase, the sample index and the channels and loads
// the register reset values; the block is ready for items as soon as reset ends.
module linear_envelope_tone_generator import letg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       restart,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] sample_value,
	output logic                       active,
	output logic                       last,
	input  logic                       cfg_write_en,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data
);

	cfg_t cfg;
	cmd_t cmd;

	// Configuration registers.
	letg_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	// Step sequencer and handshakes.
	letg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// Tone state and arithmetic.
	letg_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.restart      (restart),
		.sample_value (sample_value),
		.active       (active),
		.last         (last)
	);

endmodule

// ===== hdl/letg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the envelope tone generator.
// Depends on letg_pkg for the register indexes and the cfg_t layout.
module letg_regs import letg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Writes to an index outside the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step   <= '0;
			cfg_q.amplitude    <= AMP_RESET;
			cfg_q.tone_length  <= '0;
			cfg_q.ramp_length  <= '0;
			cfg_q.ramp_inverse <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data[STEP_W-1:0];
				REG_AMPLITUDE:    cfg_q.amplitude    <= cfg_data[AMP_W-1:0];
				REG_TONE_LENGTH:  cfg_q.tone_length  <= cfg_data[TONE_LEN_W-1:0];
				REG_RAMP_LENGTH:  cfg_q.ramp_length  <= cfg_data[RAMP_LEN_W-1:0];
				REG_RAMP_INVERSE: cfg_q.ramp_inverse <= cfg_data[RAMP_INV_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/letg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the envelope tone generator: sequences one item through the datapath steps.
// Depends on letg_pkg for the cmd_t command bundle.
module letg_ctrl import letg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCALE,
		ST_MULT,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   emit;
	logic   accept;

	// The result leaves once the output register is free; a new item may enter then too.
	assign emit     = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE) || emit;
	assign accept   = in_valid && in_ready;

	// Step commands decoded from the state.
	always_comb begin
		cmd.accept = accept;
		cmd.lookup = (state_q == ST_LOOKUP);
		cmd.scale  = (state_q == ST_SCALE);
		cmd.mult   = (state_q == ST_MULT);
		cmd.emit   = emit;
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_MULT;
				ST_MULT:   state_q <= ST_FINISH;
				ST_FINISH: begin
					if (emit) begin
						state_q <= accept ? ST_LOOKUP : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/letg_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the envelope tone generator: tone state, sine lookup, envelope and scaling.
// Depends on letg_pkg for widths, the sine table and the cmd_t and cfg_t types.
module letg_datapath import letg_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	input  cfg_t                       cfg,
	input  logic                       restart,
	output logic signed [SAMPLE_W-1:0] sample_value,
	output logic                       active,
	output logic                       last
);

	// Tone state.
	logic [INDEX_WIDTH-1:0] index_q;
	logic [STEP_W-1:0]      phase_q;

	// Accept step signals.
	logic [CMP_W-1:0]      idx;
	logic [CMP_W-1:0]      len;
	logic [CMP_W-1:0]      ramp;
	logic [CMP_W-1:0]      remain;
	logic [CMP_W-1:0]      idx_inc;
	logic [STEP_W-1:0]     phase;
	logic                  is_active;
	logic                  in_fade_in;
	logic                  in_fade_out;

	// First stage: item decoded against the configuration.
	logic                  active_s1;
	logic                  last_s1;
	logic                  full_s1;
	logic [RAMP_LEN_W-1:0] count_s1;
	logic [STEP_W-1:0]     phase_s1;

	// Second stage: sine magnitude and raw envelope.
	logic [30+SINE_ADDR_W-1:0] k_prod;
	logic [SINE_ADDR_W-1:0]    k_raw;
	logic [SINE_ADDR_W-1:0]    k;
	logic [SINE_ADDR_W-1:0]    rom_addr;
	logic [SINE_W-1:0]         mag_s2;
	logic [ENV_PROD_W-1:0]     env_prod_s2;
	logic                      active_s2;
	logic                      last_s2;
	logic                      full_s2;
	logic                      neg_s2;

	// Third stage: magnitude times amplitude and clamped envelope.
	logic [MAG_AMP_W-1:0] mag_amp_s3;
	logic [ENV_W-1:0]     env_s3;
	logic                 active_s3;
	logic                 last_s3;
	logic                 neg_s3;

	// Fourth stage: full product.
	logic [PROD_W-1:0] prod_s4;
	logic              active_s4;
	logic              last_s4;
	logic              neg_s4;

	// Rounding and saturation.
	logic [PROD_W:0]         rounded;
	logic [PROD_W-39:0]      mag_r;
	logic [SAMPLE_W-1:0]     sample_next;

	// Output register.
	logic [SAMPLE_W-1:0] sample_q;
	logic                active_q;
	logic                last_q;

	// Restart, activity test and fade region selection.
	assign idx         = restart ? '0 : CMP_W'(index_q);
	assign phase       = restart ? '0 : phase_q;
	assign len         = CMP_W'(cfg.tone_length);
	assign ramp        = CMP_W'(cfg.ramp_length);
	assign remain      = len - idx;
	assign idx_inc     = idx + CMP_W'(1);
	assign is_active   = idx < len;
	assign in_fade_in  = idx < ramp;
	assign in_fade_out = remain < ramp;

	// Tone state advances only while the tone runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
			phase_q <= '0;
		end else if (cmd.accept) begin
			index_q <= is_active ? idx_inc[INDEX_WIDTH-1:0] : idx[INDEX_WIDTH-1:0];
			phase_q <= is_active ? phase + cfg.phase_step : phase;
		end
	end

	// Decoded item. Inside a fade the count is below the ramp length.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			active_s1 <= is_active;
			last_s1   <= (idx_inc == len);
			full_s1   <= !(in_fade_in || in_fade_out);
			count_s1  <= in_fade_in ? idx[RAMP_LEN_W-1:0] : remain[RAMP_LEN_W-1:0];
			phase_s1  <= phase;
		end
	end

	// Quarter-wave table address, mirrored in odd quadrants.
	assign k_prod   = (30+SINE_ADDR_W)'(phase_s1[29:0]) *
		(30+SINE_ADDR_W)'(SINE_TABLE_DEPTH);
	assign k_raw    = k_prod[30 +: SINE_ADDR_W];
	assign k        = (k_raw > SINE_ADDR_W'(SINE_TABLE_DEPTH)) ?
		SINE_ADDR_W'(SINE_TABLE_DEPTH) : k_raw;
	assign rom_addr = phase_s1[30] ? SINE_ADDR_W'(SINE_TABLE_DEPTH) - k : k;

	// Table read and envelope slope product.
	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			mag_s2      <= SINE_ROM[rom_addr];
			env_prod_s2 <= ENV_PROD_W'(count_s1) * ENV_PROD_W'(cfg.ramp_inverse);
			active_s2   <= active_s1;
			last_s2     <= last_s1;
			full_s2     <= full_s1;
			neg_s2      <= phase_s1[31];
		end
	end

	// Amplitude scaling and envelope clamp at 1.0.
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			mag_amp_s3 <= MAG_AMP_W'(mag_s2) * MAG_AMP_W'(cfg.amplitude);
			if (full_s2 || (env_prod_s2 > ENV_PROD_W'(ENV_ONE))) begin
				env_s3 <= ENV_ONE;
			end else begin
				env_s3 <= env_prod_s2[ENV_W-1:0];
			end
			active_s3 <= active_s2;
			last_s3   <= last_s2;
			neg_s3    <= neg_s2;
		end
	end

	// Envelope multiply.
	always_ff @(posedge clk) begin
		if (cmd.mult) begin
			prod_s4   <= PROD_W'(mag_amp_s3) * PROD_W'(env_s3);
			active_s4 <= active_s3;
			last_s4   <= last_s3;
			neg_s4    <= neg_s3;
		end
	end

	// Round half away from zero, then saturate with the sine's sign.
	assign rounded = (PROD_W+1)'(prod_s4) + ((PROD_W+1)'(1) << 38);
	assign mag_r   = rounded[PROD_W:39];

	always_comb begin
		if (!active_s4) begin
			sample_next = '0;
		end else if (neg_s4) begin
			if (mag_r > (PROD_W-38)'(32768)) begin
				sample_next = 16'h8000;
			end else begin
				sample_next = SAMPLE_W'(16'd0 - mag_r[SAMPLE_W-1:0]);
			end
		end else begin
			if (mag_r > (PROD_W-38)'(32767)) begin
				sample_next = 16'h7fff;
			end else begin
				sample_next = mag_r[SAMPLE_W-1:0];
			end
		end
	end

	// Output register, loaded when the result is handed over.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sample_q <= sample_next;
			active_q <= active_s4;
			last_q   <= active_s4 && last_s4;
		end
	end

	assign sample_value = signed'(sample_q);
	assign active       = active_q;
	assign last         = last_q;

endmodule

// ===== hdl/letg_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the envelope tone generator, bound to the top level.
// Depends on letg_pkg for the port widths.
module letg_checker import letg_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] sample_value,
	input logic                       active,
	input logic                       last
);

	// A result held by the receiver keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_value) && $stable(last))
		else $error("stalled result changed");

	// The final sample of a tone is always an active one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> active)
		else $error("last flagged on an inactive sample");

	// Past the tone the output is silent.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> sample_value == '0)
		else $error("inactive sample is not zero");

	// Items are never accepted back to back.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("items accepted in consecutive cycles");

endmodule

bind linear_envelope_tone_generator letg_checker u_letg_checker (.*);
